FILE: src/wvs_pkg.sv
package wvs_pkg;

    localparam int JOINT_COUNT_DEF = 128;

    localparam int IDX_W  = 7;
    localparam int POS_W  = 32;
    localparam int QUAT_W = 16;
    localparam int BIAS_W = 17;

    // fraction bits of the quaternion and of the bias
    localparam int QUAT_FRAC = 14;
    localparam int BIAS_FRAC = 16;

    // internal datapath widths
    localparam int LANE_A_W = 36;                  // local position or t component
    localparam int PROD_W   = LANE_A_W + QUAT_W;   // one lane product
    localparam int SUM_W    = 56;                  // sum of up to four lane products
    localparam int T_W      = 36;                  // t = q v, Q20.16
    localparam int R_W      = 40;                  // r = t q*, Q24.16
    localparam int RO_W     = R_W + 1;             // r plus joint position
    localparam int MUL_W    = 60;                  // (r + offset) * bias, Q28.32
    localparam int TERM_W   = 44;                  // weighted term, Q28.16
    localparam int ACC_W    = 48;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_WEIGHT = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [IDX_W-1:0]         joint_index;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
        logic [BIAS_W-1:0]        bias;
        logic                     last_weight;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] vertex_x;
        logic signed [POS_W-1:0] vertex_y;
        logic signed [POS_W-1:0] vertex_z;
    } t_out_item;

endpackage

FILE: src/weighted_vertex_skinning.sv
// Skins mesh vertices from weighted joint-local positions. A load transaction (op = 0) writes
// one joint entry (orientation quaternion Q1.14, position Q16.16) into a single-port joint
// memory; the table has no reset and an entry must be loaded before a weight references
// it. A weight transaction (op = 1) reads its joint entry into a register, rotates the
// local position as q v q* on twelve shared multiplier lanes (one pass for q v, one for
// the product with q*), adds the joint position and multiplies by the bias, then adds
// the rounded term into 48-bit saturating accumulators. A load is accepted every cycle
// while no weight is in progress; a weight holds off new transactions from its acceptance
// through the memory read, the two passes over the multiplier lanes, the bias multiply
// and the accumulate. The weight marked last emits the vertex saturated to 32 bits and
// clears the accumulators; if the previous vertex still sits unread in the output register,
// that weight holds in its accumulate step until the output register frees up.
module weighted_vertex_skinning #(
    parameter int JOINT_COUNT = wvs_pkg::JOINT_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wvs_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wvs_pkg::t_out_item  o_out_data
);

    localparam int ADDR_W  = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int EXT_W   = ADDR_W + wvs_pkg::IDX_W;
    localparam int QW      = wvs_pkg::QUAT_W;
    localparam int PW      = wvs_pkg::POS_W;
    localparam int ENTRY_W = 4 * QW + 3 * PW;
    localparam int SUM_W   = wvs_pkg::SUM_W;
    localparam int ACC_W   = wvs_pkg::ACC_W;
    localparam int QF      = wvs_pkg::QUAT_FRAC;
    localparam int BF      = wvs_pkg::BIAS_FRAC;

    localparam logic signed [SUM_W-1:0] HALF_Q = SUM_W'(1) << (QF - 1);
    localparam logic signed [wvs_pkg::MUL_W-1:0] HALF_B = wvs_pkg::MUL_W'(1) << (BF - 1);
    localparam logic signed [ACC_W+1:0] ACC_HI = (ACC_W+2)'({1'b0, {(ACC_W-1){1'b1}}});
    localparam logic signed [ACC_W+1:0] ACC_LO = -ACC_HI - (ACC_W+2)'(1);
    localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'({1'b0, {(PW-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] OUT_LO = -OUT_HI - ACC_W'(1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TROT = 5'b00010,
        S_RROT = 5'b00100,
        S_BIAS = 5'b01000,
        S_ACC  = 5'b10000
    } t_state;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] x);
        logic signed [ACC_W+1:0] y;
        y = x;
        if (x > ACC_HI) y = ACC_HI;
        if (x < ACC_LO) y = ACC_LO;
        return y[ACC_W-1:0];
    endfunction

    function automatic logic signed [PW-1:0] sat_out(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] y;
        y = x;
        if (x > OUT_HI) y = OUT_HI;
        if (x < OUT_LO) y = OUT_LO;
        return y[PW-1:0];
    endfunction

    t_state r_state, n_state;

    logic [ENTRY_W-1:0] mem [JOINT_COUNT];
    logic [ENTRY_W-1:0] r_rd;

    logic signed [PW-1:0]                   r_v [3];
    logic [wvs_pkg::BIAS_W-1:0]             r_bias;
    logic                                   r_last;
    logic                                   r_hit;
    logic signed [wvs_pkg::T_W-1:0]         r_t [4];
    logic signed [wvs_pkg::R_W-1:0]         r_r [3];
    logic signed [wvs_pkg::MUL_W-1:0]       r_m [3];
    logic signed [ACC_W-1:0]                r_sum [3];
    logic                                   r_out_valid;
    wvs_pkg::t_out_item                     r_out_data;

    logic              in_accept;
    logic              in_range;
    logic [EXT_W-1:0]  idx_ext;
    logic [ADDR_W-1:0] addr;
    logic              out_free;
    logic              acc_done;

    logic signed [QW-1:0] q_w, q_x, q_y, q_z;
    logic signed [PW-1:0] off [3];

    logic signed [wvs_pkg::LANE_A_W-1:0] lane_a [12];
    logic signed [QW-1:0]                lane_b [12];
    logic signed [wvs_pkg::PROD_W-1:0]   lane_p [12];
    logic signed [SUM_W-1:0]             se [12];
    logic signed [SUM_W-1:0]             t_acc [4];
    logic signed [SUM_W-1:0]             r_acc [3];
    logic signed [wvs_pkg::RO_W-1:0]     ro [3];
    logic signed [wvs_pkg::MUL_W-1:0]    mul_p [3];
    logic signed [wvs_pkg::MUL_W-1:0]    m_rnd [3];
    logic signed [wvs_pkg::TERM_W-1:0]   term [3];
    logic signed [ACC_W-1:0]             n_acc [3];
    logic signed [wvs_pkg::LANE_A_W-1:0] v_ext [3];
    logic signed [wvs_pkg::LANE_A_W-1:0] t_ext [4];

    assign in_accept = i_in_valid && !o_in_stall;
    assign idx_ext   = {{ADDR_W{1'b0}}, i_in_data.joint_index};
    assign addr      = idx_ext[ADDR_W-1:0];
    assign in_range  = idx_ext < EXT_W'(JOINT_COUNT);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign acc_done  = (r_state == S_ACC) && (!r_last || out_free);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // joint memory: one write or one read per transaction
    always_ff @(posedge i_clk) begin
        if (in_accept && i_in_data.op == wvs_pkg::OP_LOAD && in_range) begin
            mem[addr] <= {i_in_data.quat_w, i_in_data.quat_x, i_in_data.quat_y,
                          i_in_data.quat_z, i_in_data.pos_x, i_in_data.pos_y,
                          i_in_data.pos_z};
        end
        if (in_accept && i_in_data.op == wvs_pkg::OP_WEIGHT) begin
            r_rd <= mem[addr];
        end
    end

    assign q_w    = r_rd[ENTRY_W-1 -: QW];
    assign q_x    = r_rd[ENTRY_W-QW-1 -: QW];
    assign q_y    = r_rd[ENTRY_W-2*QW-1 -: QW];
    assign q_z    = r_rd[ENTRY_W-3*QW-1 -: QW];
    assign off[0] = r_rd[3*PW-1 -: PW];
    assign off[1] = r_rd[2*PW-1 -: PW];
    assign off[2] = r_rd[PW-1:0];

    // shared multiplier lanes: q v in S_TROT, t q* in S_RROT
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v_ext[i] = wvs_pkg::LANE_A_W'(r_v[i]);
        end
        for (int i = 0; i < 4; i++) begin
            t_ext[i] = wvs_pkg::LANE_A_W'(r_t[i]);
        end
        if (r_state == S_TROT) begin
            lane_a[0]  = v_ext[0];  lane_b[0]  = q_x;
            lane_a[1]  = v_ext[1];  lane_b[1]  = q_y;
            lane_a[2]  = v_ext[2];  lane_b[2]  = q_z;
            lane_a[3]  = v_ext[0];  lane_b[3]  = q_w;
            lane_a[4]  = v_ext[2];  lane_b[4]  = q_y;
            lane_a[5]  = v_ext[1];  lane_b[5]  = q_z;
            lane_a[6]  = v_ext[1];  lane_b[6]  = q_w;
            lane_a[7]  = v_ext[0];  lane_b[7]  = q_z;
            lane_a[8]  = v_ext[2];  lane_b[8]  = q_x;
            lane_a[9]  = v_ext[2];  lane_b[9]  = q_w;
            lane_a[10] = v_ext[1];  lane_b[10] = q_x;
            lane_a[11] = v_ext[0];  lane_b[11] = q_y;
        end else begin
            lane_a[0]  = t_ext[0];  lane_b[0]  = q_x;
            lane_a[1]  = t_ext[1];  lane_b[1]  = q_w;
            lane_a[2]  = t_ext[2];  lane_b[2]  = q_z;
            lane_a[3]  = t_ext[3];  lane_b[3]  = q_y;
            lane_a[4]  = t_ext[0];  lane_b[4]  = q_y;
            lane_a[5]  = t_ext[1];  lane_b[5]  = q_z;
            lane_a[6]  = t_ext[2];  lane_b[6]  = q_w;
            lane_a[7]  = t_ext[3];  lane_b[7]  = q_x;
            lane_a[8]  = t_ext[0];  lane_b[8]  = q_z;
            lane_a[9]  = t_ext[1];  lane_b[9]  = q_y;
            lane_a[10] = t_ext[2];  lane_b[10] = q_x;
            lane_a[11] = t_ext[3];  lane_b[11] = q_w;
        end
        for (int k = 0; k < 12; k++) begin
            lane_p[k] = wvs_pkg::PROD_W'(lane_a[k]) * wvs_pkg::PROD_W'(lane_b[k]);
            se[k]     = SUM_W'(lane_p[k]);
        end
    end

    // t components in w, x, y, z order; r in x, y, z; both rounded half up below
    always_comb begin
        t_acc[0] = -(se[0] + se[1] + se[2]) + HALF_Q;
        t_acc[1] = se[3] + se[4] - se[5] + HALF_Q;
        t_acc[2] = se[6] + se[7] - se[8] + HALF_Q;
        t_acc[3] = se[9] + se[10] - se[11] + HALF_Q;
        r_acc[0] = -se[0] + se[1] - se[2] + se[3] + HALF_Q;
        r_acc[1] = -se[4] + se[5] + se[6] - se[7] + HALF_Q;
        r_acc[2] = -se[8] - se[9] + se[10] + se[11] + HALF_Q;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ro[i]    = wvs_pkg::RO_W'(r_r[i]) + wvs_pkg::RO_W'(off[i]);
            mul_p[i] = wvs_pkg::MUL_W'(ro[i])
                     * wvs_pkg::MUL_W'(signed'({1'b0, r_bias}));
            m_rnd[i] = r_m[i] + HALF_B;
            term[i]  = m_rnd[i][wvs_pkg::TERM_W+BF-1:BF];
            if (r_hit) begin
                n_acc[i] = sat_acc((ACC_W+2)'(r_sum[i]) + (ACC_W+2)'(term[i]));
            end else begin
                n_acc[i] = r_sum[i];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && i_in_data.op == wvs_pkg::OP_WEIGHT) n_state = S_TROT;
            end
            S_TROT: n_state = S_RROT;
            S_RROT: n_state = S_BIAS;
            S_BIAS: n_state = S_ACC;
            S_ACC: begin
                if (acc_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (acc_done && r_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (acc_done) begin
                for (int i = 0; i < 3; i++) begin
                    r_sum[i] <= r_last ? '0 : n_acc[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_v[0] <= i_in_data.pos_x;
            r_v[1] <= i_in_data.pos_y;
            r_v[2] <= i_in_data.pos_z;
            r_bias <= i_in_data.bias;
            r_last <= i_in_data.last_weight;
            r_hit  <= in_range;
        end
        if (r_state == S_TROT) begin
            for (int i = 0; i < 4; i++) begin
                r_t[i] <= t_acc[i][wvs_pkg::T_W+QF-1:QF];
            end
        end
        if (r_state == S_RROT) begin
            for (int i = 0; i < 3; i++) begin
                r_r[i] <= r_acc[i][wvs_pkg::R_W+QF-1:QF];
            end
        end
        if (r_state == S_BIAS) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i] <= mul_p[i];
            end
        end
        if (acc_done && r_last) begin
            r_out_data.vertex_x <= sat_out(n_acc[0]);
            r_out_data.vertex_y <= sat_out(n_acc[1]);
            r_out_data.vertex_z <= sat_out(n_acc[2]);
        end
    end

    a_out_from_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_ACC))
        else $error("result appeared outside the accumulate step");

    a_weight_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.op == wvs_pkg::OP_WEIGHT) |=> (r_state == S_TROT))
        else $error("weight transaction did not start the rotation");

    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.op == wvs_pkg::OP_LOAD) |=> (r_state == S_IDLE))
        else $error("load transaction left the idle state");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_done && r_last) |=> (r_sum[0] == '0 && r_sum[1] == '0 && r_sum[2] == '0))
        else $error("accumulator not cleared after vertex output");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("pending vertex dropped");

endmodule

FILE: bench/weighted_vertex_skinning_tb.sv
module weighted_vertex_skinning_tb;

    localparam int JOINTS       = wvs_pkg::JOINT_COUNT_DEF;
    localparam int ITEM_TARGET  = 1650;
    localparam int QUIET_TAIL   = 150;
    // worst quiet stretch is a sender gap, a weight pass and a stalled output
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam int U            = 65536;

    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    localparam logic signed [wvs_pkg::QUAT_W-1:0] QUAT_EDGES [5] = '{
        16'sh8000, 16'sh7FFF, 16'sh4000, -16'sh4000, 16'sh0000
    };

    typedef struct {
        wvs_pkg::t_in_item  item;
        bit                 typed;
        wvs_pkg::t_out_item vtx;
    } t_dir_row;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    wvs_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    wvs_pkg::t_out_item out_data;

    // joint table as seen by the predictor, plus the running vertex sums
    wvs_pkg::t_in_item  joint_entry [JOINTS];
    bit                 joint_loaded [JOINTS];
    longint             acc_x, acc_y, acc_z;

    wvs_pkg::t_out_item pending_vertices [$];
    t_dir_row  dir_rows [$];
    int        mismatches  = 0;
    int        items_sent  = 0;
    int        idle_cycles = 0;
    int        stall_left  = 0;
    bit        quiet       = 1'b0;
    bit        dense       = 1'b0;

    weighted_vertex_skinning i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic longint round_half_up(input longint x, input int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint acc_sat(input longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    function automatic logic signed [wvs_pkg::POS_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return 32'(v);
    endfunction

    // returns 1 when the transaction closes a vertex
    function automatic bit predict_vertex(input wvs_pkg::t_in_item it,
                                          output wvs_pkg::t_out_item vtx);
        wvs_pkg::t_in_item jnt;
        longint   qw, qx, qy, qz, vx, vy, vz, b;
        longint   tw, tx, ty, tz, rx, ry, rz;
        vtx = '0;
        if (it.op == wvs_pkg::OP_LOAD) begin
            if (int'(it.joint_index) < JOINTS) begin
                joint_entry[it.joint_index]  = it;
                joint_loaded[it.joint_index] = 1'b1;
            end
            return 1'b0;
        end
        if (int'(it.joint_index) < JOINTS) begin
            jnt = joint_entry[it.joint_index];
            qw = longint'($signed(jnt.quat_w));
            qx = longint'($signed(jnt.quat_x));
            qy = longint'($signed(jnt.quat_y));
            qz = longint'($signed(jnt.quat_z));
            vx = longint'($signed(it.pos_x));
            vy = longint'($signed(it.pos_y));
            vz = longint'($signed(it.pos_z));
            b  = longint'($unsigned(it.bias));

            // t = q (0, v)
            tw = round_half_up(-(qx * vx + qy * vy + qz * vz), wvs_pkg::QUAT_FRAC);
            tx = round_half_up(qw * vx + qy * vz - qz * vy, wvs_pkg::QUAT_FRAC);
            ty = round_half_up(qw * vy + qz * vx - qx * vz, wvs_pkg::QUAT_FRAC);
            tz = round_half_up(qw * vz + qx * vy - qy * vx, wvs_pkg::QUAT_FRAC);
            // r = t q*
            rx = round_half_up(-tw * qx + tx * qw - ty * qz + tz * qy, wvs_pkg::QUAT_FRAC);
            ry = round_half_up(-tw * qy + tx * qz + ty * qw - tz * qx, wvs_pkg::QUAT_FRAC);
            rz = round_half_up(-tw * qz - tx * qy + ty * qx + tz * qw, wvs_pkg::QUAT_FRAC);

            rx += longint'($signed(jnt.pos_x));
            ry += longint'($signed(jnt.pos_y));
            rz += longint'($signed(jnt.pos_z));

            acc_x = acc_sat(acc_x + round_half_up(rx * b, wvs_pkg::BIAS_FRAC));
            acc_y = acc_sat(acc_y + round_half_up(ry * b, wvs_pkg::BIAS_FRAC));
            acc_z = acc_sat(acc_z + round_half_up(rz * b, wvs_pkg::BIAS_FRAC));
        end
        if (!it.last_weight) return 1'b0;
        vtx.vertex_x = clamp32(acc_x);
        vtx.vertex_y = clamp32(acc_y);
        vtx.vertex_z = clamp32(acc_z);
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        return 1'b1;
    endfunction

    function automatic void add_row(input logic op, input int idx,
                                    input int px, input int py, input int pz,
                                    input int qx, input int qy, input int qz, input int qw,
                                    input int bias, input bit last, input bit typed = 1'b0,
                                    input int ex = 0, input int ey = 0, input int ez = 0);
        t_dir_row r;
        r.item.op          = op;
        r.item.joint_index = 7'(idx);
        r.item.pos_x       = px;
        r.item.pos_y       = py;
        r.item.pos_z       = pz;
        r.item.quat_x      = 16'(qx);
        r.item.quat_y      = 16'(qy);
        r.item.quat_z      = 16'(qz);
        r.item.quat_w      = 16'(qw);
        r.item.bias        = 17'(bias);
        r.item.last_weight = last;
        r.typed            = typed;
        r.vtx.vertex_x     = ex;
        r.vtx.vertex_y     = ey;
        r.vtx.vertex_z     = ez;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic wvs_pkg::t_in_item rand_fill();
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(wvs_pkg::t_in_item)-1:0];
    endfunction

    function automatic logic signed [wvs_pkg::POS_W-1:0] rand_pos();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: case ($urandom_range(0, 3))
                   0: return 32'sh7FFF_FFFF;
                   1: return 32'sh8000_0000;
                   2: return 32'sh0;
                   default: return -32'sd1;
               endcase
            default: return 32'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
        endcase
    endfunction

    function automatic logic [wvs_pkg::BIAS_W-1:0] rand_bias();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 17'd65536;
            2: return 17'($urandom_range(0, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [wvs_pkg::IDX_W-1:0] pick_loaded();
        int j;
        j = $urandom_range(0, JOINTS - 1);
        while (!joint_loaded[j]) j = $urandom_range(0, JOINTS - 1);
        return 7'(j);
    endfunction

    function automatic wvs_pkg::t_in_item make_load();
        wvs_pkg::t_in_item it;
        real      a, b, c, d, nrm;
        it             = rand_fill();
        it.op          = wvs_pkg::OP_LOAD;
        it.joint_index = 7'($urandom_range(0, JOINTS - 1));
        it.pos_x       = rand_pos();
        it.pos_y       = rand_pos();
        it.pos_z       = rand_pos();
        it.last_weight = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 9)) inside
            [0:5]: begin
                // unit quaternion from a random direction in 4-space
                a   = real'(int'($urandom_range(0, 32768)) - 16384);
                b   = real'(int'($urandom_range(0, 32768)) - 16384);
                c   = real'(int'($urandom_range(0, 32768)) - 16384);
                d   = real'(int'($urandom_range(0, 32768)) - 16384);
                nrm = $sqrt(a * a + b * b + c * c + d * d);
                if (nrm < 1.0) begin
                    a   = 16384.0;
                    b   = 0.0;
                    c   = 0.0;
                    d   = 0.0;
                    nrm = 16384.0;
                end
                it.quat_w = 16'($rtoi(a * 16384.0 / nrm));
                it.quat_x = 16'($rtoi(b * 16384.0 / nrm));
                it.quat_y = 16'($rtoi(c * 16384.0 / nrm));
                it.quat_z = 16'($rtoi(d * 16384.0 / nrm));
            end
            [6:7]: begin
                it.quat_w = 16'(int'($urandom_range(0, 32768)) - 16384);
                it.quat_x = 16'(int'($urandom_range(0, 32768)) - 16384);
                it.quat_y = 16'(int'($urandom_range(0, 32768)) - 16384);
                it.quat_z = 16'(int'($urandom_range(0, 32768)) - 16384);
            end
            8: ; // raw 16-bit quaternion from rand_fill
            default: begin
                it.quat_w = QUAT_EDGES[$urandom_range(0, 4)];
                it.quat_x = QUAT_EDGES[$urandom_range(0, 4)];
                it.quat_y = QUAT_EDGES[$urandom_range(0, 4)];
                it.quat_z = QUAT_EDGES[$urandom_range(0, 4)];
            end
        endcase
        return it;
    endfunction

    task automatic send_item(input wvs_pkg::t_in_item it, input bit typed = 1'b0,
                             input wvs_pkg::t_out_item typed_vtx = '0);
        wvs_pkg::t_out_item vtx;
        bit        closes;
        if (!quiet && !dense && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
        closes = predict_vertex(it, vtx);
        if (closes) pending_vertices = {pending_vertices, (typed ? typed_vtx : vtx)};
        items_sent++;
    endtask

    task automatic send_vertex(input int n_weights);
        wvs_pkg::t_in_item it;
        for (int k = 0; k < n_weights; k++) begin
            // joint updates landing in the middle of a vertex
            if ($urandom_range(0, 9) == 0) send_item(make_load());
            it             = rand_fill();
            it.op          = wvs_pkg::OP_WEIGHT;
            it.joint_index = pick_loaded();
            it.pos_x       = rand_pos();
            it.pos_y       = rand_pos();
            it.pos_z       = rand_pos();
            it.bias        = rand_bias();
            it.last_weight = (k == n_weights - 1);
            send_item(it);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_vertices.size() != 0);
    endtask

    task automatic in_data_noise();
        wvs_pkg::t_in_item it;
        it = rand_fill();
        if (it.op == wvs_pkg::OP_WEIGHT) it.joint_index = pick_loaded();
        send_item(it);
    endtask

    // result side: checking, output stall bursts, idle counting
    always @(posedge clk) begin
        wvs_pkg::t_out_item want;
        if (!rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall) begin
                if (pending_vertices.size() == 0) begin
                    report_mismatch("vertex with none pending, x", out_data.vertex_x, 0);
                end else begin
                    want = pending_vertices.pop_front();
                    if (out_data.vertex_x !== want.vertex_x)
                        report_mismatch("vertex_x", out_data.vertex_x, want.vertex_x);
                    if (out_data.vertex_y !== want.vertex_y)
                        report_mismatch("vertex_y", out_data.vertex_y, want.vertex_y);
                    if (out_data.vertex_z !== want.vertex_z)
                        report_mismatch("vertex_z", out_data.vertex_z, want.vertex_z);
                end
            end
        end
        if (!rst_n || quiet || dense)
            stall_left = 0;
        else if (stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 18);
        else if (stall_left != 0)
            stall_left--;
        out_stall <= (stall_left != 0);
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge clk);
        $display("weighted_vertex_skinning_tb NOT OK");
        $finish;
    end

    initial begin
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        foreach (joint_loaded[j]) joint_loaded[j] = 1'b0;

        // op, joint, pos x/y/z, quat x/y/z/w, bias, last [, typed x/y/z]
        add_row(wvs_pkg::OP_LOAD,     0, 0, 0, 0, 0, 0, 0, 16384, 0, 1'b0);
        add_row(wvs_pkg::OP_WEIGHT,   0, U, 2*U, -3*U, 0, 0, 0, 0, U, 1'b1, 1'b1,
                U, 2*U, -3*U);
        add_row(wvs_pkg::OP_WEIGHT,   0, 5*U, 5*U, 5*U, 0, 0, 0, 0, 0, 1'b1, 1'b1, 0, 0, 0);
        // last mark on a load is ignored
        add_row(wvs_pkg::OP_LOAD,     1, U, -U, U/2, 0, 0, 0, 16384, 0, 1'b1);
        add_row(wvs_pkg::OP_WEIGHT,   1, 0, 0, 0, 0, 0, 0, 0, U, 1'b0);
        add_row(wvs_pkg::OP_WEIGHT,   0, U, U, U, 0, 0, 0, 0, U/2, 1'b1, 1'b1,
                98304, -32768, 65536);
        // rounding: exact half goes up
        add_row(wvs_pkg::OP_WEIGHT,   0, 32768, -32768, 32767, 0, 0, 0, 0, 1, 1'b1, 1'b1,
                1, 0, 0);
        add_row(wvs_pkg::OP_WEIGHT,   0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, U, 1'b1,
                1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        add_row(wvs_pkg::OP_WEIGHT,   0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 131071,
                1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        add_row(wvs_pkg::OP_LOAD,   127, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                -32768, -32768, -32768, -32768, 131071, 1'b0);
        add_row(wvs_pkg::OP_WEIGHT, 127, U, 0, 0, 0, 0, 0, 0, U, 1'b1);
        add_row(wvs_pkg::OP_LOAD,   126, -1, 1, 32'h7FFF_FFFF, 32767, 32767, 32767, 32767, 0,
                1'b0);
        add_row(wvs_pkg::OP_WEIGHT, 126, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                0, 0, 0, 0, 131071, 1'b0);
        add_row(wvs_pkg::OP_WEIGHT, 127, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                0, 0, 0, 0, 131071, 1'b1);
        // quarter turn about z
        add_row(wvs_pkg::OP_LOAD,     2, 0, 0, 0, 0, 0, 11585, 11585, 0, 1'b0);
        add_row(wvs_pkg::OP_WEIGHT,   2, U, 0, 0, 0, 0, 0, 0, U, 1'b1);
        add_row(wvs_pkg::OP_LOAD,     3, 0, 0, 0, 0, 0, 0, -16384, 0, 1'b0);
        add_row(wvs_pkg::OP_WEIGHT,   3, -7*U, 3*U, 2*U, 0, 0, 0, 0, U, 1'b1, 1'b1,
                -7*U, 3*U, 2*U);
        // half turn about x
        add_row(wvs_pkg::OP_LOAD,     4, 0, 0, 0, 16384, 0, 0, 0, 0, 1'b0);
        add_row(wvs_pkg::OP_WEIGHT,   4, U, 2*U, 3*U, 0, 0, 0, 0, U, 1'b1, 1'b1,
                U, -2*U, -3*U);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].vtx);
        drain_results();

        repeat (12) send_item(make_load());
        while (items_sent < ITEM_TARGET) begin
            quiet = (items_sent >= ITEM_TARGET - QUIET_TAIL);
            if ($urandom_range(0, 79) == 0) dense = !dense;
            case ($urandom_range(0, 99)) inside
                [0:9]:   send_item(make_load());
                [10:15]: begin
                    // raw transaction, weights still kept on loaded joints
                    in_data_noise();
                end
                [16:17]: drain_results();
                default: send_vertex(($urandom_range(0, 5) == 0) ? $urandom_range(5, 12)
                                                                  : $urandom_range(1, 4));
            endcase
        end

        in_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("weighted_vertex_skinning_tb OK");
        else
            $display("weighted_vertex_skinning_tb NOT OK");
        $finish;
    end

endmodule

FILE: weighted_vertex_skinning.f
src/wvs_pkg.sv
src/weighted_vertex_skinning.sv
bench/weighted_vertex_skinning_tb.sv
